>>> design/cfe_pkg.sv
// Package for the complex zero-forcing equalizer.
// Holds default sizes and the sideband bit positions; used by the top level.
package cfe_pkg;

    // default sample format Q2.13
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF    = 13;

    // result sideband bit positions in tuser
    localparam int USER_ZERO_DIV = 0;
    localparam int USER_SAT      = 1;
    localparam int USER_WIDTH    = 2;

endpackage

>>> design/complex_zero_forcing_equalizer.sv
// Complex zero-forcing one-tap equalizer: sample / channel, rounded and saturated.
// Depends on cfe_pkg for default sizes and sideband bit positions.
//
// Usage:
//   Input channel s_axis_*: one item per accepted beat carries the received sample
//   (data_re, data_im) and the channel coefficient (chan_re, chan_im).
//   Output channel m_axis_*: one result per item, (eq_re, eq_im) in tdata and the
//   flags zero_divisor and saturated in tuser.
//   Pipeline: one multiply stage, one sum stage, one setup stage, one restoring
//   division stage per quotient bit (SAMPLE_WIDTH+2 stages, each one subtract and
//   compare for the real and the imaginary part), and one round/clip stage.
//   That is SAMPLE_WIDTH+6 register stages (22 at default); tvalid is the valid
//   bit of the round/clip stage.
//   Throughput is one item per cycle while the receiver does not stall; the division chain sets the depth.
//   Reset clears all stage valid bits; the pipeline is empty and ready after it.
//   When the receiver stalls, each stage holds until the one after it frees up;
//   empty stages still fill, so s_axis_tready stays high until every stage holds
//   an item. No item is lost or repeated.
module complex_zero_forcing_equalizer #(
    parameter int SAMPLE_WIDTH = cfe_pkg::SAMPLE_WIDTH_DEF,
    parameter int FRAC_BITS    = cfe_pkg::FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // fields from bit 0 up: data_re, data_im, chan_re, chan_im, zero fill
    input  logic [((4*SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // fields from bit 0 up: eq_re, eq_im, zero fill
    output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // fields from bit 0 up: zero_divisor, saturated
    output logic [cfe_pkg::USER_WIDTH-1:0] m_axis_tuser
);
    import cfe_pkg::*;

    localparam int W   = SAMPLE_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int PW  = 2*W;
    localparam int NW  = 2*W+1;
    localparam int QW  = W+2;
    localparam int ND  = W+2;
    localparam int NS  = ND+4;
    localparam int RWA = 2*W+F+1;
    localparam int RWB = 3*W+2;
    localparam int RW  = (RWA > RWB) ? RWA : RWB;
    localparam int ODW = ((2*W+7)/8)*8;

    localparam logic [QW-1:0] CAP      = QW'(1) << (W+1);
    localparam logic [W:0]    HALF_NEG = (W+1)'(1) << (W-1);
    localparam logic [W:0]    HALF_POS = HALF_NEG - (W+1)'(1);

    // stage valid bits and per-stage advance
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] rdy;

    always_comb
    begin
        rdy[NS-1] = ~vld_reg[NS-1] | m_axis_tready;
        for (int i = NS-2; i >= 0; i--)
        begin
            rdy[i] = ~vld_reg[i] | rdy[i+1];
        end
    end

    assign s_axis_tready = rdy[0];
    assign m_axis_tvalid = vld_reg[NS-1];

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= s_axis_tvalid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // stage A: form the six products
    logic signed [W-1:0]  data_re, data_im, chan_re, chan_im;
    logic signed [PW-1:0] ac_reg, bd_reg, bc_reg, ad_reg, cc_reg, dd_reg;

    assign data_re = s_axis_tdata[W-1:0];
    assign data_im = s_axis_tdata[2*W-1:W];
    assign chan_re = s_axis_tdata[3*W-1:2*W];
    assign chan_im = s_axis_tdata[4*W-1:3*W];

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            ac_reg <= data_re * chan_re;
            bd_reg <= data_im * chan_im;
            bc_reg <= data_im * chan_re;
            ad_reg <= data_re * chan_im;
            cc_reg <= chan_re * chan_re;
            dd_reg <= chan_im * chan_im;
        end
    end

    // stage B: numerators and channel power
    logic signed [NW-1:0] num_re_reg, num_im_reg;
    logic [PW-1:0]        pow_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            num_re_reg <= NW'(ac_reg) + NW'(bd_reg);
            num_im_reg <= NW'(bc_reg) - NW'(ad_reg);
            pow_reg    <= $unsigned(cc_reg) + $unsigned(dd_reg);
        end
    end

    // stage C and division chain; index 0 is the setup stage
    logic [RW-1:0] rem_re_reg [0:ND];
    logic [RW-1:0] rem_im_reg [0:ND];
    logic [QW-1:0] q_re_reg   [0:ND];
    logic [QW-1:0] q_im_reg   [0:ND];
    logic [PW-1:0] den_reg    [0:ND];
    logic [ND:0]   neg_re_reg, neg_im_reg, ovf_re_reg, ovf_im_reg, zero_reg;

    logic [PW-1:0] mag_re, mag_im;
    logic [RW-1:0] rem0_re, rem0_im, den_top;

    // take magnitudes and scale numerators by the fraction plus round bit
    always_comb
    begin
        mag_re  = num_re_reg[NW-1] ? PW'(-num_re_reg) : PW'(num_re_reg);
        mag_im  = num_im_reg[NW-1] ? PW'(-num_im_reg) : PW'(num_im_reg);
        rem0_re = RW'(mag_re) << (F+1);
        rem0_im = RW'(mag_im) << (F+1);
        den_top = RW'(pow_reg) << ND;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            rem_re_reg[0] <= rem0_re;
            rem_im_reg[0] <= rem0_im;
            q_re_reg[0]   <= '0;
            q_im_reg[0]   <= '0;
            den_reg[0]    <= pow_reg;
            neg_re_reg[0] <= num_re_reg[NW-1];
            neg_im_reg[0] <= num_im_reg[NW-1];
            ovf_re_reg[0] <= rem0_re >= den_top;
            ovf_im_reg[0] <= rem0_im >= den_top;
            zero_reg[0]   <= pow_reg == '0;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar j = 0; j < ND; j++)
    begin : g_div
        logic [RW-1:0] trial;
        logic          take_re, take_im;

        assign trial   = RW'(den_reg[j]) << (ND-1-j);
        assign take_re = rem_re_reg[j] >= trial;
        assign take_im = rem_im_reg[j] >= trial;

        always_ff @(posedge clk)
        begin
            if (rdy[j+3])
            begin
                rem_re_reg[j+1] <= take_re ? rem_re_reg[j] - trial : rem_re_reg[j];
                rem_im_reg[j+1] <= take_im ? rem_im_reg[j] - trial : rem_im_reg[j];
                q_re_reg[j+1]   <= {q_re_reg[j][QW-2:0], take_re};
                q_im_reg[j+1]   <= {q_im_reg[j][QW-2:0], take_im};
                den_reg[j+1]    <= den_reg[j];
                neg_re_reg[j+1] <= neg_re_reg[j];
                neg_im_reg[j+1] <= neg_im_reg[j];
                ovf_re_reg[j+1] <= ovf_re_reg[j];
                ovf_im_reg[j+1] <= ovf_im_reg[j];
                zero_reg[j+1]   <= zero_reg[j];
            end
        end
    end

    // output stage: cap, round half away, clip, restore sign
    logic [QW-1:0] qf_re, qf_im;
    logic [W:0]    m_re, m_im, lim_re, lim_im;
    logic          sat_re, sat_im;
    logic [W-1:0]  eq_re_next, eq_im_next;
    logic [W-1:0]  eq_re_reg, eq_im_reg;
    logic          zdiv_reg, sat_reg;

    always_comb
    begin
        qf_re  = (ovf_re_reg[ND] || q_re_reg[ND] > CAP) ? CAP : q_re_reg[ND];
        qf_im  = (ovf_im_reg[ND] || q_im_reg[ND] > CAP) ? CAP : q_im_reg[ND];
        m_re   = (W+1)'(((QW+1)'(qf_re) + (QW+1)'(1)) >> 1);
        m_im   = (W+1)'(((QW+1)'(qf_im) + (QW+1)'(1)) >> 1);
        lim_re = neg_re_reg[ND] ? HALF_NEG : HALF_POS;
        lim_im = neg_im_reg[ND] ? HALF_NEG : HALF_POS;
        sat_re = m_re > lim_re;
        sat_im = m_im > lim_im;
        if (sat_re)
        begin
            m_re = lim_re;
        end
        if (sat_im)
        begin
            m_im = lim_im;
        end
        eq_re_next = neg_re_reg[ND] ? W'(-m_re) : W'(m_re);
        eq_im_next = neg_im_reg[ND] ? W'(-m_im) : W'(m_im);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[NS-1])
        begin
            eq_re_reg <= zero_reg[ND] ? '0 : eq_re_next;
            eq_im_reg <= zero_reg[ND] ? '0 : eq_im_next;
            zdiv_reg  <= zero_reg[ND];
            sat_reg   <= ~zero_reg[ND] & (sat_re | sat_im);
        end
    end

    assign m_axis_tdata = ODW'({eq_im_reg, eq_re_reg});

    always_comb
    begin
        m_axis_tuser                = '0;
        m_axis_tuser[USER_ZERO_DIV] = zdiv_reg;
        m_axis_tuser[USER_SAT]      = sat_reg;
    end

    // a zero channel gives a clean zero result
    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NS-1] && zdiv_reg |-> eq_re_reg == '0 && eq_im_reg == '0 && !sat_reg)
        else $error("zero divisor result not cleared");

    // a clipped result sits at a range limit
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NS-1] && sat_reg |->
            eq_re_reg == W'(HALF_POS) || eq_re_reg == W'(HALF_NEG) ||
            eq_im_reg == W'(HALF_POS) || eq_im_reg == W'(HALF_NEG))
        else $error("saturated flag without clipped part");

    // any empty stage lets a new item in
    a_bubble_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !(&vld_reg) |-> s_axis_tready)
        else $error("input stalled with an empty stage");

    // a held result keeps its stage valid
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NS-1] && !m_axis_tready |=> vld_reg[NS-1] && $stable(eq_re_reg))
        else $error("stalled result lost");

endmodule
